// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- rtl/mpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants of the min-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // Operation codes of the kind field
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Capacity register
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Status flags of one result
  typedef struct packed {
    logic ok;
    logic head_valid;
  } rsp_flags_t;

endpackage

// ----- rtl/mpq_req_if.sv -----
// ----------------------------------------------------------------------------
// mpq_req_if
// Request channel: one operation per transaction.
// ----------------------------------------------------------------------------
interface mpq_req_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- rtl/mpq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mpq_rsp_if
// Result channel: one result per transaction.
// ----------------------------------------------------------------------------
interface mpq_rsp_if #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CNT_W       = 5
);
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic signed [VALUE_WIDTH-1:0] removed_value;
  logic                          head_valid;
  logic signed [VALUE_WIDTH-1:0] head_value;
  logic [CNT_W-1:0]              entry_count;

  modport source (output valid, output ok, output removed_value, output head_valid,
                  output head_value, output entry_count, input ready);
  modport sink   (input valid, input ok, input removed_value, input head_valid,
                  input head_value, input entry_count, output ready);
endinterface

// ----- rtl/mpq_store.sv -----
// ----------------------------------------------------------------------------
// mpq_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mpq_store #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned AW         = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic signed [VALUE_WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic signed [VALUE_WIDTH-1:0] rdata_o
);

  logic signed [VALUE_WIDTH-1:0] mem [DEPTH];
  logic signed [VALUE_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer and shared compare unit: insert, remove with compaction, rescan.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpq_ctrl #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned AW         = $clog2(DEPTH),
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mpq_pkg::CFG_W-1:0]      max_entries_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_kind_i,
  input  logic signed [VALUE_WIDTH-1:0]  in_value_i,
  output logic                           resp_valid_o,
  input  logic                           resp_ready_i,
  output mpq_pkg::rsp_flags_t            resp_flags_o,
  output logic signed [VALUE_WIDTH-1:0]  resp_removed_o,
  output logic signed [VALUE_WIDTH-1:0]  resp_head_o,
  output logic [CNT_W-1:0]               resp_count_o,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic signed [VALUE_WIDTH-1:0]  mem_wdata_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic signed [VALUE_WIDTH-1:0]  mem_rdata_i
);

  localparam int unsigned CMP_W = (CNT_W > mpq_pkg::CFG_W) ? CNT_W : mpq_pkg::CFG_W;

  mpq_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]              count_q, count_d;
  logic [AW-1:0]                 min_pos_q, min_pos_d;
  logic signed [VALUE_WIDTH-1:0] head_q, head_d;
  logic signed [VALUE_WIDTH-1:0] removed_q, removed_d;
  logic                          ok_q, ok_d;
  logic [CNT_W-1:0]              rd_idx_q, rd_idx_d;
  logic                          p_vld_q, p_vld_d;
  logic [AW-1:0]                 p_idx_q, p_idx_d;
  logic                          found_q, found_d;
  logic signed [VALUE_WIDTH-1:0] best_q, best_d;
  logic [AW-1:0]                 best_pos_q, best_pos_d;

  logic          can_insert;
  logic          issue;
  logic          scan_done;
  logic          skip;
  logic          above;
  logic          take;
  logic [AW-1:0] dest;

  assign can_insert = (CMP_W'(count_q) < CMP_W'(max_entries_i))
                   && (count_q != CNT_W'(DEPTH));

  // Walk the old entries in order; the removed one is skipped, later ones move down.
  assign issue     = (rd_idx_q < count_q);
  assign scan_done = !issue && !p_vld_q;
  assign skip      = (p_idx_q == min_pos_q);
  assign above     = (p_idx_q > min_pos_q);
  assign dest      = above ? (p_idx_q - AW'(1)) : p_idx_q;
  assign take      = p_vld_q && !skip && (!found_q || (mem_rdata_i < best_q));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if ((in_kind_i == mpq_pkg::KIND_REMOVE) && (count_q != '0)) begin
            state_d = mpq_pkg::ST_SCAN;
          end else begin
            state_d = mpq_pkg::ST_RESP;
          end
        end
      end
      mpq_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = mpq_pkg::ST_RESP;
        end
      end
      mpq_pkg::ST_RESP: begin
        if (resp_ready_i) begin
          state_d = mpq_pkg::ST_IDLE;
        end
      end
      default: state_d = mpq_pkg::ST_IDLE;
    endcase
  end

  // Outputs and store port
  always_comb begin
    in_ready_o   = (state_q == mpq_pkg::ST_IDLE);
    resp_valid_o = (state_q == mpq_pkg::ST_RESP);
    mem_raddr_o  = rd_idx_q[AW-1:0];
    mem_we_o     = 1'b0;
    mem_waddr_o  = count_q[AW-1:0];
    mem_wdata_o  = in_value_i;
    unique case (state_q)
      mpq_pkg::ST_IDLE: begin
        mem_we_o = in_valid_i && (in_kind_i == mpq_pkg::KIND_INSERT) && can_insert;
      end
      mpq_pkg::ST_SCAN: begin
        mem_we_o    = p_vld_q && above;
        mem_waddr_o = dest;
        mem_wdata_o = mem_rdata_i;
      end
      mpq_pkg::ST_RESP: begin
        mem_we_o = 1'b0;
      end
      default: mem_we_o = 1'b0;
    endcase
  end

  assign resp_flags_o.ok         = ok_q;
  assign resp_flags_o.head_valid = (count_q != '0);
  assign resp_removed_o          = removed_q;
  assign resp_head_o             = (count_q != '0) ? head_q : '0;
  assign resp_count_o            = count_q;

  // Datapath next values
  always_comb begin
    count_d    = count_q;
    min_pos_d  = min_pos_q;
    head_d     = head_q;
    removed_d  = removed_q;
    ok_d       = ok_q;
    rd_idx_d   = rd_idx_q;
    p_vld_d    = 1'b0;
    p_idx_d    = p_idx_q;
    found_d    = found_q;
    best_d     = best_q;
    best_pos_d = best_pos_q;
    unique case (state_q)
      mpq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == mpq_pkg::KIND_INSERT) begin
            ok_d      = can_insert;
            removed_d = '0;
            if (can_insert) begin
              count_d = count_q + CNT_W'(1);
              if ((count_q == '0) || (in_value_i < head_q)) begin
                head_d    = in_value_i;
                min_pos_d = count_q[AW-1:0];
              end
            end
          end else begin
            ok_d      = (count_q != '0);
            removed_d = (count_q != '0) ? head_q : '0;
            rd_idx_d  = '0;
            found_d   = 1'b0;
          end
        end
      end
      mpq_pkg::ST_SCAN: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
          p_vld_d  = 1'b1;
          p_idx_d  = rd_idx_q[AW-1:0];
        end
        if (take) begin
          found_d    = 1'b1;
          best_d     = mem_rdata_i;
          best_pos_d = dest;
        end
        if (scan_done) begin
          count_d   = count_q - CNT_W'(1);
          min_pos_d = found_q ? best_pos_q : '0;
          head_d    = found_q ? best_q : head_q;
        end
      end
      mpq_pkg::ST_RESP: begin
        p_vld_d = 1'b0;
      end
      default: p_vld_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mpq_pkg::ST_IDLE;
      count_q   <= '0;
      min_pos_q <= '0;
      p_vld_q   <= 1'b0;
      rd_idx_q  <= '0;
      found_q   <= 1'b0;
      ok_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      min_pos_q <= min_pos_d;
      p_vld_q   <= p_vld_d;
      rd_idx_q  <= rd_idx_d;
      found_q   <= found_d;
      ok_q      <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q     <= head_d;
    removed_q  <= removed_d;
    p_idx_q    <= p_idx_d;
    best_q     <= best_d;
    best_pos_q <= best_pos_d;
  end

  `ASSERT_NEVER(a_count_le_depth, clk_i, rst_ni, count_q > CNT_W'(DEPTH))
  `ASSERT_PROP(a_min_in_range, clk_i, rst_ni, ((state_q == mpq_pkg::ST_IDLE) && (count_q != '0)) |-> (CNT_W'(min_pos_q) < count_q))
  `ASSERT_NEVER(a_shift_in_range, clk_i, rst_ni, (state_q == mpq_pkg::ST_SCAN) && mem_we_o && (CNT_W'(mem_waddr_o) >= count_q))
  `ASSERT_PROP(a_remove_drops_one, clk_i, rst_ni, ((state_q == mpq_pkg::ST_SCAN) && scan_done) |=> (count_q == CNT_W'($past(count_q) - CNT_W'(1))))

endmodule

// ----- rtl/min_priority_queue_array_top.sv -----
// ----------------------------------------------------------------------------
// min_priority_queue_array_top
// Min-priority queue over an insertion-ordered store with a minimum index.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req_i    in         valid / ready        kind, value
//   rsp_o    out        valid / ready        ok, removed_value, head_valid,
//                                            head_value, entry_count
//   cfg      in         cfg_we_i (no ready)  cfg_wdata_i = max_entries
//
// An insert, or a remove on an empty queue, goes from acceptance through the
// sequencer's result state into the result register. A remove makes one pass
// over the store through its single read port, compacting later entries and
// rescanning for the minimum with one shared compare per cycle. The request
// side is ready only while the sequencer is idle. The result register lets a
// new transaction enter while the previous result still waits; the sequencer
// holds when it is full.
// Reset (rst_ni, asynchronous) empties the queue and sets capacity to 16;
// store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module min_priority_queue_array_top #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mpq_pkg::CFG_W-1:0] cfg_wdata_i,
  mpq_req_if.sink                   req_i,
  mpq_rsp_if.source                 rsp_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Capacity register
  logic [mpq_pkg::CFG_W-1:0] max_entries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= mpq_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      max_entries_q <= cfg_wdata_i;
    end
  end

  // Sequencer to store
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic signed [VALUE_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic signed [VALUE_WIDTH-1:0] mem_rdata;

  // Sequencer to result register
  logic                          resp_valid;
  logic                          resp_ready;
  mpq_pkg::rsp_flags_t           resp_flags;
  logic signed [VALUE_WIDTH-1:0] resp_removed;
  logic signed [VALUE_WIDTH-1:0] resp_head;
  logic [CNT_W-1:0]              resp_count;

  mpq_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_entries_i  (max_entries_q),
    .in_valid_i     (req_i.valid),
    .in_ready_o     (req_i.ready),
    .in_kind_i      (req_i.kind),
    .in_value_i     (req_i.value),
    .resp_valid_o   (resp_valid),
    .resp_ready_i   (resp_ready),
    .resp_flags_o   (resp_flags),
    .resp_removed_o (resp_removed),
    .resp_head_o    (resp_head),
    .resp_count_o   (resp_count),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  mpq_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result register: load when empty or being drained, hold otherwise.
  logic                          out_valid_q;
  mpq_pkg::rsp_flags_t           out_flags_q;
  logic signed [VALUE_WIDTH-1:0] out_removed_q;
  logic signed [VALUE_WIDTH-1:0] out_head_q;
  logic [CNT_W-1:0]              out_count_q;

  assign resp_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_ready) begin
      out_valid_q <= resp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_valid && resp_ready) begin
      out_flags_q   <= resp_flags;
      out_removed_q <= resp_removed;
      out_head_q    <= resp_head;
      out_count_q   <= resp_count;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.ok            = out_flags_q.ok;
  assign rsp_o.removed_value = out_removed_q;
  assign rsp_o.head_valid    = out_flags_q.head_valid;
  assign rsp_o.head_value    = out_head_q;
  assign rsp_o.entry_count   = out_count_q;

endmodule
